// File: design/sdr_pkg.sv
// Shared types and constants for the scanline delta row decoder.
// No dependencies; imported by every design module.
package sdr_pkg;

  localparam int BYTE_W      = 8;
  localparam int ROW_BYTES_W = 10;
  localparam int HEIGHT_W    = 15;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST    = 10'd20;
  localparam logic [HEIGHT_W-1:0]    IMAGE_HEIGHT_RST = 15'd160;

  // Stream parsing phase
  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_FLAG,
    PH_LIT,
    PH_DONE
  } phase_t;

  // Sequencer state
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_COPY,
    ST_LIT
  } seq_state_t;

  // One decoded byte handed to the output register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } emit_t;

endpackage

// File: design/sdr_row_store.sv
// Previous-row byte store: one write port, one registered read port.
// Depends on sdr_pkg for the byte width.
module sdr_row_store #(
  parameter int DEPTH  = 512,
  parameter int ADDR_W = 9
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [sdr_pkg::BYTE_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [sdr_pkg::BYTE_W-1:0] rdata
);
  import sdr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/sdr_ctrl.sv
// Sequencer: parses header/flag/literal bytes and steps the column counter
// and compare unit once per decoded byte. Depends on sdr_pkg.
module sdr_ctrl #(
  parameter int MAX_ROW_BYTES = 512,
  parameter int COL_W         = 10,
  parameter int ADDR_W        = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sdr_pkg::BYTE_W-1:0]      in_byte,
  input  logic                           start_of_image,
  input  logic [sdr_pkg::ROW_BYTES_W-1:0] row_bytes,
  input  logic [sdr_pkg::HEIGHT_W-1:0]    image_height,
  input  logic                           out_free,
  output sdr_pkg::emit_t                 emit,
  output logic                           mem_we,
  output logic [ADDR_W-1:0]              mem_waddr,
  output logic [sdr_pkg::BYTE_W-1:0]      mem_wdata,
  output logic                           mem_re,
  output logic [ADDR_W-1:0]              mem_raddr,
  input  logic [sdr_pkg::BYTE_W-1:0]      rd_data
);
  import sdr_pkg::*;

  localparam int CMP_W = (COL_W > ROW_BYTES_W) ? COL_W : ROW_BYTES_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_ROW_BYTES - 1);

  seq_state_t          state, state_next;
  phase_t              phase, phase_next;
  logic [BYTE_W-1:0]   flag_bits, flag_bits_next;
  logic [2:0]          bit_pos, bit_pos_next;
  logic [COL_W-1:0]    column, column_next;
  logic [HEIGHT_W-1:0] row_count, row_count_next;
  logic [ADDR_W-1:0]   clr_addr, clr_addr_next;
  logic [BYTE_W-1:0]   lit_byte, lit_byte_next;

  logic [COL_W-1:0]    row_len;
  logic [COL_W-1:0]    col_n;
  logic [3:0]          bit_n;
  logic [HEIGHT_W-1:0] rc_n;
  logic                more, row_end, last_row, run_copy;
  logic [BYTE_W-1:0]   copy_byte, emit_byte;

  // effective row length: zero means one, saturate at store depth
  always_comb begin
    if (row_bytes == '0) begin
      row_len = COL_W'(1);
    end else if (CMP_W'(row_bytes) > CMP_W'(MAX_ROW_BYTES)) begin
      row_len = COL_W'(MAX_ROW_BYTES);
    end else begin
      row_len = COL_W'(row_bytes);
    end
  end

  // shared step unit: increments and compares for the byte being emitted
  assign col_n     = column + COL_W'(1);
  assign bit_n     = {1'b0, bit_pos} + 4'd1;
  assign rc_n      = row_count + HEIGHT_W'(1);
  assign more      = !bit_n[3] && (col_n < row_len) && !flag_bits[~bit_n[2:0]];
  assign row_end   = (col_n >= row_len);
  assign last_row  = (rc_n >= image_height);
  assign run_copy  = (column < row_len) && !flag_bits[~bit_pos];
  assign copy_byte = (row_count != '0) ? rd_data : '0;
  assign emit_byte = (state == ST_LIT) ? lit_byte : copy_byte;

  assign in_stall = (state != ST_IDLE);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= PH_HDR1;
      flag_bits <= '0;
      bit_pos   <= '0;
      column    <= '0;
      row_count <= '0;
      clr_addr  <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      flag_bits <= flag_bits_next;
      bit_pos   <= bit_pos_next;
      column    <= column_next;
      row_count <= row_count_next;
      clr_addr  <= clr_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    lit_byte <= lit_byte_next;
  end

  // next state and outputs
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    flag_bits_next = flag_bits;
    bit_pos_next   = bit_pos;
    column_next    = column;
    row_count_next = row_count;
    clr_addr_next  = clr_addr;
    lit_byte_next  = lit_byte;
    emit           = '0;
    mem_we         = 1'b0;
    mem_waddr      = column[ADDR_W-1:0];
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = column[ADDR_W-1:0];

    case (state)
      // zero the row store once after reset
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + ADDR_W'(1);
        end
      end

      // take one request
      ST_IDLE: begin
        if (in_valid) begin
          if (start_of_image) begin
            phase_next     = PH_HDR2;
            flag_bits_next = '0;
            bit_pos_next   = '0;
            column_next    = '0;
            row_count_next = '0;
          end else begin
            case (phase)
              PH_HDR1: phase_next = PH_HDR2;
              PH_HDR2: phase_next = (row_count >= image_height) ? PH_DONE : PH_FLAG;
              PH_FLAG: begin
                flag_bits_next = in_byte;
                bit_pos_next   = '0;
                state_next     = ST_RUN;
              end
              PH_LIT: begin
                lit_byte_next = in_byte;
                state_next    = (column < row_len) ? ST_LIT : ST_RUN;
              end
              default: ;
            endcase
          end
        end
      end

      // decide on a copy without emitting anything yet
      ST_RUN: begin
        if (run_copy) begin
          mem_re     = 1'b1;
          state_next = ST_COPY;
        end else begin
          state_next = ST_IDLE;
          if (column >= row_len) begin
            column_next    = '0;
            bit_pos_next   = '0;
            row_count_next = rc_n;
            phase_next     = last_row ? PH_DONE : PH_FLAG;
          end else begin
            phase_next = PH_LIT;
          end
        end
      end

      // emit a copied or literal byte and step to the next column
      ST_COPY, ST_LIT: begin
        if (out_free) begin
          emit.valid   = 1'b1;
          emit.data    = emit_byte;
          emit.last    = !more;
          emit.done    = !more && row_end && last_row;
          mem_we       = 1'b1;
          mem_wdata    = emit_byte;
          column_next  = col_n;
          bit_pos_next = bit_n[2:0];
          if (more) begin
            mem_re     = 1'b1;
            mem_raddr  = col_n[ADDR_W-1:0];
            state_next = ST_COPY;
          end else begin
            state_next = ST_IDLE;
            if (row_end) begin
              column_next    = '0;
              bit_pos_next   = '0;
              row_count_next = rc_n;
              phase_next     = last_row ? PH_DONE : PH_FLAG;
            end else if (bit_n[3]) begin
              bit_pos_next = '0;
              phase_next   = PH_FLAG;
            end else begin
              phase_next = PH_LIT;
            end
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/scanline_delta_row_decoder_top.sv
// Scanline delta row decoder. A request byte is taken only in the idle state,
// and in_stall stays high until the sequencer is done with it: a flag byte
// emits each copied byte in turn, and a literal emits its byte and the copies
// after it (nothing when its row already ended), as set by the column step
// sequencer and the single row store read port. Output stalls hold it.
// After rst the row store is zeroed with in_stall high.
module scanline_delta_row_decoder_top #(
  parameter int MAX_ROW_BYTES = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sdr_pkg::BYTE_W-1:0]       in_byte,
  input  logic                            start_of_image,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sdr_pkg::BYTE_W-1:0]       out_byte,
  output logic                            last_of_run,
  output logic                            image_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdr_pkg::HEIGHT_W-1:0]     cfg_data
);
  import sdr_pkg::*;

  localparam int COL_W  = $clog2(MAX_ROW_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_ROW_BYTES);

  logic [ROW_BYTES_W-1:0] row_bytes;
  logic [HEIGHT_W-1:0]    image_height;
  emit_t                  emit;
  logic                   out_free;
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]      mem_wdata, rd_data;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes    <= ROW_BYTES_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_BYTES:    row_bytes    <= cfg_data[ROW_BYTES_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  sdr_ctrl #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES),
    .COL_W         (COL_W),
    .ADDR_W        (ADDR_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .start_of_image (start_of_image),
    .row_bytes      (row_bytes),
    .image_height   (image_height),
    .out_free       (out_free),
    .emit           (emit),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .rd_data        (rd_data)
  );

  sdr_row_store #(
    .DEPTH  (MAX_ROW_BYTES),
    .ADDR_W (ADDR_W)
  ) u_row_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_byte    <= emit.data;
      last_of_run <= emit.last;
      image_done  <= emit.done;
    end
  end

  // checks
  a_emit_fits: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> out_free)
    else $error("byte emitted while output register is occupied");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && image_done |-> last_of_run)
    else $error("image_done without last_of_run");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall)
    else $error("request taken before row store clear");

endmodule
